FILE: hdl/utf8rte_pkg.sv
// Shared types and constants for the UTF-8 reading-time estimator.
// No dependencies; all other files but utf8rte_fifo use it by scoped names.
`default_nettype none

package utf8rte_pkg;

    // Classified code point tokens passed from the decoder to the counter
    localparam int TOK_W = 2;
    localparam logic [TOK_W-1:0] TOK_SEP  = 2'd0;
    localparam logic [TOK_W-1:0] TOK_WORD = 2'd1;
    localparam logic [TOK_W-1:0] TOK_CJK  = 2'd2;
    localparam logic [TOK_W-1:0] TOK_END  = 2'd3;

    localparam int QUEUE_DEPTH_DEF    = 4;
    localparam int MAX_TEXT_BYTES_DEF = 4096;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int CNT_W   = 13;
    localparam int UNITS_W = 14;
    localparam int DUR_W   = 8;
    localparam int RATE_W  = 16;
    localparam int SEC_W   = 8;

    // units * 256 + rate - 1 fits in 23 bits
    localparam int DIV_N = UNITS_W + 8 + 1;

    // x / 5 == (x * 0xCCCD) >> 18 for x below 2^18
    localparam logic [15:0] RECIP_5   = 16'hCCCD;
    localparam int          RECIP_SH  = 18;
    localparam logic [UNITS_W-1:0] UNITS_MAX = 14'h3FFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd768;
    localparam logic [SEC_W-1:0]  MIN_RESET  = 8'd1;
    localparam logic [SEC_W-1:0]  MAX_RESET  = 8'd30;

    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic [SEC_W-1:0]  min_sec;
        logic [SEC_W-1:0]  max_sec;
    } cfg_t;

endpackage

`default_nettype wire

FILE: hdl/utf8rte_fifo.sv
// Small token queue between the decoder front and the counting back end.
// Uses utf8rte_pkg only through the parameters handed in from above.
`default_nettype none

module utf8rte_fifo #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utf8rte_front.sv
// Decoder front: takes text bytes, resolves at most one UTF-8 code point a
// cycle while the queue has room, queuing classified tokens. Uses utf8rte_pkg.
`default_nettype none

module utf8rte_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,
    input  wire logic                        s_tlast,
    output logic                             q_push,
    output logic [utf8rte_pkg::TOK_W-1:0]    q_data,
    input  wire logic                        q_full
);

    localparam int BW = utf8rte_pkg::BYTE_W;
    localparam int CW = utf8rte_pkg::CP_W;

    function automatic logic [1:0] lead_need(input logic [BW-1:0] b);
        logic [1:0] n;
        n = 2'd0;
        if (b[7:5] == 3'b110)
        begin
            n = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            n = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [utf8rte_pkg::TOK_W-1:0] classify(input logic [CW-1:0] c);
        logic cjk;
        logic word;
        logic [utf8rte_pkg::TOK_W-1:0] t;
        cjk = (c >= 21'h3040 && c <= 21'h30FF) || (c >= 21'h3400 && c <= 21'h4DBF) ||
              (c >= 21'h4E00 && c <= 21'h9FFF) || (c >= 21'hAC00 && c <= 21'hD7AF) ||
              (c >= 21'hF900 && c <= 21'hFAFF);
        if (c < 21'h80)
        begin
            word = (c >= 21'h30 && c <= 21'h39) || (c >= 21'h41 && c <= 21'h5A) ||
                   (c >= 21'h61 && c <= 21'h7A) || (c == 21'h27);
        end
        else
        begin
            word = !cjk && !(c >= 21'h2000 && c <= 21'h206F) &&
                   !(c >= 21'h3000 && c <= 21'h303F);
        end
        if (cjk)
        begin
            t = utf8rte_pkg::TOK_CJK;
        end
        else if (word)
        begin
            t = utf8rte_pkg::TOK_WORD;
        end
        else
        begin
            t = utf8rte_pkg::TOK_SEP;
        end
        return t;
    endfunction

    logic [BW-1:0] held_reg [4];
    logic [BW-1:0] held_next [4];
    logic [2:0]    cnt_reg, cnt_next;
    logic          end_reg, end_next;

    logic [BW-1:0] cb [4];
    logic [2:0]    ccnt;
    logic          acc;
    logic [1:0]    need;
    logic [1:0]    need_r;
    logic          res;
    logic          ok;
    logic          is_end;
    logic          emit;
    logic [CW-1:0] cp;
    logic [2:0]    sh;
    logic [2:0]    idx;

    assign need_r   = lead_need(held_reg[0]);
    assign s_tready = !end_reg &&
                      !((cnt_reg != 3'd0) && (need_r == 2'd0 || cnt_reg > {1'b0, need_r}));
    assign acc      = s_tvalid && s_tready;

    always_comb
    begin
        // working view: held bytes with this beat appended
        for (int i = 0; i < 4; i++)
        begin
            cb[i] = (acc && cnt_reg == 3'(i)) ? s_tdata : held_reg[i];
        end
        ccnt = cnt_reg + {2'b00, acc};
        need = lead_need(cb[0]);
        res  = (ccnt != 3'd0) && (need == 2'd0 || ccnt > {1'b0, need});

        ok = 1'b1;
        for (int i = 1; i < 4; i++)
        begin
            if (2'(i) <= need && cb[i][7:6] != 2'b10)
            begin
                ok = 1'b0;
            end
        end

        cp = {13'd0, cb[0]};
        sh = 3'd1;
        if (res && ok && need != 2'd0)
        begin
            sh = {1'b0, need} + 3'd1;
            case (need)
                2'd1:    cp = {10'd0, cb[0][4:0], cb[1][5:0]};
                2'd2:    cp = {5'd0, cb[0][3:0], cb[1][5:0], cb[2][5:0]};
                2'd3:    cp = {cb[0][2:0], cb[1][5:0], cb[2][5:0], cb[3][5:0]};
                default: cp = {13'd0, cb[0]};
            endcase
        end

        // at end of text: truncated lead goes out alone, then the end token
        is_end = end_reg && (ccnt == 3'd0);
        emit   = res || end_reg;
        q_push = emit && !q_full;
        q_data = is_end ? utf8rte_pkg::TOK_END : classify(cp);

        held_next = cb;
        cnt_next  = ccnt;
        end_next  = end_reg || (acc && s_tlast);
        idx       = 3'd0;
        if (q_push)
        begin
            if (res)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    idx = 3'(i) + sh;
                    held_next[i] = (idx < 3'd4) ? cb[idx[1:0]] : cb[i];
                end
                cnt_next = ccnt - sh;
            end
            else
            begin
                cnt_next = 3'd0;
            end
            if (is_end)
            begin
                end_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            end_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("front: held byte count out of range");

    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_data == utf8rte_pkg::TOK_END) |-> (cnt_reg == 3'd0 && end_reg))
        else $error("front: end token pushed with bytes still held");

endmodule

`default_nettype wire

FILE: hdl/utf8rte_div.sv
// Restoring divider, one quotient bit per cycle, for the duration step.
// Widths come from utf8rte_pkg.
`default_nettype none

module utf8rte_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [utf8rte_pkg::DIV_N-1:0]     dividend,
    input  wire logic [utf8rte_pkg::RATE_W-1:0]    divisor,
    output logic                                   done,
    output logic [utf8rte_pkg::DIV_N-1:0]          quotient
);

    localparam int N  = utf8rte_pkg::DIV_N;
    localparam int DW = utf8rte_pkg::RATE_W;
    localparam int CW = $clog2(N);

    logic [N-1:0]  quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    assign trial    = {rem_reg, quo_reg[N-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign take     = (trial >= {1'b0, dvs_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], take};
            rem_reg <= take ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utf8rte_back.sv
// Counting back end: pops tokens, counts words and CJK characters, and at
// end of text works out units and duration. Uses utf8rte_pkg, utf8rte_div.
`default_nettype none

module utf8rte_back #(
    parameter int MAX_TEXT_BYTES = utf8rte_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire utf8rte_pkg::cfg_t              cfg,
    input  wire logic                           tok_valid,
    input  wire logic [utf8rte_pkg::TOK_W-1:0]  tok_data,
    output logic                                tok_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [47:0]                         m_tdata
);

    localparam int CW = utf8rte_pkg::CNT_W;
    localparam int UW = utf8rte_pkg::UNITS_W;
    localparam int DW = utf8rte_pkg::DUR_W;
    localparam int N  = utf8rte_pkg::DIV_N;
    localparam int PW = 31;
    localparam logic [CW-1:0] CNT_CAP =
        CW'((MAX_TEXT_BYTES < 8191) ? MAX_TEXT_BYTES : 8191);

    localparam logic [2:0] S_RUN   = 3'd0;
    localparam logic [2:0] S_UNITS = 3'd1;
    localparam logic [2:0] S_DIVGO = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        return (c < CNT_CAP) ? c + 1'b1 : c;
    endfunction

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] word_reg, word_next;
    logic [CW-1:0] cjk_reg, cjk_next;
    logic          inw_reg, inw_next;
    logic [PW-1:0] prod_reg;
    logic [UW-1:0] units_reg;
    logic [DW-1:0] dur_reg;

    logic          out_valid_reg;
    logic [DW-1:0] out_dur_reg;
    logic [CW-1:0] out_word_reg;
    logic [CW-1:0] out_cjk_reg;
    logic [UW-1:0] out_units_reg;

    logic [14:0]   cjk_x;
    logic [UW:0]   units_sum;
    logic          div_start;
    logic          div_done;
    logic [N-1:0]  div_dividend;
    logic [N-1:0]  div_q;
    logic [N:0]    secs;
    logic [N:0]    secs_lo;
    logic          load_out;

    assign tok_pop      = (state_reg == S_RUN);
    assign cjk_x        = 15'({cjk_reg, 1'b0}) + 15'd4;
    assign units_sum    = (UW+1)'(word_reg) + (UW+1)'(prod_reg[PW-1:utf8rte_pkg::RECIP_SH]);
    assign div_start    = (state_reg == S_DIVGO) && (units_reg != '0) && (cfg.rate != '0);
    assign div_dividend = N'({units_reg, 8'd0}) + N'(cfg.rate) - N'(1);
    assign load_out     = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // ceil(units / rate) + 1, raised to min then lowered to max
    assign secs    = (N+1)'(div_q) + (N+1)'(1);
    assign secs_lo = (secs < (N+1)'(cfg.min_sec)) ? (N+1)'(cfg.min_sec) : secs;

    utf8rte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cfg.rate),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        cjk_next   = cjk_reg;
        inw_next   = inw_reg;
        case (state_reg)
            S_RUN:
            begin
                if (tok_valid)
                begin
                    case (tok_data)
                        utf8rte_pkg::TOK_CJK:
                        begin
                            if (inw_reg)
                            begin
                                word_next = sat_inc(word_reg);
                            end
                            inw_next = 1'b0;
                            cjk_next = sat_inc(cjk_reg);
                        end
                        utf8rte_pkg::TOK_WORD:
                        begin
                            inw_next = 1'b1;
                        end
                        utf8rte_pkg::TOK_END:
                        begin
                            if (inw_reg)
                            begin
                                word_next = sat_inc(word_reg);
                            end
                            inw_next   = 1'b0;
                            state_next = S_UNITS;
                        end
                        default:
                        begin
                            if (inw_reg)
                            begin
                                word_next = sat_inc(word_reg);
                            end
                            inw_next = 1'b0;
                        end
                    endcase
                end
            end
            S_UNITS:
            begin
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                state_next = div_start ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    word_next  = '0;
                    cjk_next   = '0;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            word_reg      <= '0;
            cjk_reg       <= '0;
            inw_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
            cjk_reg   <= cjk_next;
            inw_reg   <= inw_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // cjk count is settled when the end token is popped
        if (state_reg == S_RUN)
        begin
            prod_reg <= PW'(cjk_x) * PW'(utf8rte_pkg::RECIP_5);
        end
        if (state_reg == S_UNITS)
        begin
            units_reg <= (units_sum > (UW+1)'(utf8rte_pkg::UNITS_MAX)) ?
                         utf8rte_pkg::UNITS_MAX : units_sum[UW-1:0];
        end
        if (state_reg == S_DIVGO)
        begin
            if (units_reg == '0)
            begin
                dur_reg <= '0;
            end
            else
            begin
                dur_reg <= cfg.max_sec;
            end
        end
        if (state_reg == S_DIV && div_done)
        begin
            dur_reg <= (secs_lo > (N+1)'(cfg.max_sec)) ? cfg.max_sec : secs_lo[DW-1:0];
        end
        if (load_out)
        begin
            out_dur_reg   <= dur_reg;
            out_word_reg  <= word_reg;
            out_cjk_reg   <= cjk_reg;
            out_units_reg <= units_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_units_reg, out_cjk_reg, out_word_reg, out_dur_reg};

    a_zero_units: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_units_reg == '0) |-> (out_dur_reg == '0))
        else $error("back: nonzero duration for empty text");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (word_reg <= CNT_CAP) && (cjk_reg <= CNT_CAP))
        else $error("back: counter above saturation cap");

    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("back: divider finished outside divide state");

endmodule

`default_nettype wire

FILE: hdl/utf8_reading_time_estimator.sv
// UTF-8 reading-time estimator, top level: config registers, decoder front,
// token queue and counting back end. Uses utf8rte_pkg and all utf8rte_* modules.
//
// Usage:
//   s_* channel: one text byte per beat, s_tlast on the final byte of a text.
//   m_* channel: one result beat per text, after its last byte.
//   cfg_we/cfg_index/cfg_wdata: register writes (0 rate Q8.8, 1 min, 2 max),
//   taken on any edge with cfg_we high; write only while the block is idle.
// Throughput: one byte per cycle inside a text while the queue has room. The front
//   takes no byte while it queues the end marker of a text, while a lead cut off
//   by the end of text goes out, or while it reads bytes again after a broken
//   sequence. After popping an end marker the back end pops nothing until it has
//   worked out the units, run or skipped the divide and loaded the output register.
// With an empty queue m_tvalid rises once the last byte is taken, the end marker
//   is queued and popped, the units are worked out, the bit-serial divide runs and
//   the output register is loaded. Empty texts or a zero rate skip the divide.
// Stall: a result waits in the output register while m_tready is low; the
//   front keeps taking bytes of the next text until the queue (default 4) fills.
// Reset: config returns to 768 / 1 / 30; counters and the held byte count clear.
`default_nettype none

module utf8_reading_time_estimator #(
    parameter int MAX_TEXT_BYTES = utf8rte_pkg::MAX_TEXT_BYTES_DEF,
    parameter int QUEUE_DEPTH    = utf8rte_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] duration_seconds, [20:8] word_total,
                                        // [33:21] cjk_total, [47:34] reading_units
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    utf8rte_pkg::cfg_t cfg_reg;

    logic                          q_push;
    logic [utf8rte_pkg::TOK_W-1:0] q_wdata;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_valid;
    logic [utf8rte_pkg::TOK_W-1:0] q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate    <= utf8rte_pkg::RATE_RESET;
            cfg_reg.min_sec <= utf8rte_pkg::MIN_RESET;
            cfg_reg.max_sec <= utf8rte_pkg::MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                utf8rte_pkg::CFG_RATE: cfg_reg.rate    <= cfg_wdata;
                utf8rte_pkg::CFG_MIN:  cfg_reg.min_sec <= cfg_wdata[7:0];
                utf8rte_pkg::CFG_MAX:  cfg_reg.max_sec <= cfg_wdata[7:0];
                default:               ;
            endcase
        end
    end

    utf8rte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_data   (q_wdata),
        .q_full   (q_full)
    );

    utf8rte_fifo #(
        .WIDTH (utf8rte_pkg::TOK_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rdata)
    );

    utf8rte_back #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_valid (q_valid),
        .tok_data  (q_rdata),
        .tok_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
